[design/fblp_pkg.sv]
// Package for the frame buffer line plotter.
// Holds screen geometry, field widths, action and pen codes, and the
// command word passed from the front end to the back end.
package fblp_pkg;

  localparam int COLUMNS    = 132;
  localparam int PAGES      = 8;
  localparam int ROWS       = PAGES * 8;
  localparam int STORE_SIZE = PAGES * COLUMNS;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int PAGE_W     = (PAGES > 1) ? $clog2(PAGES) : 1;

  localparam int CRD_W = 12;
  localparam int PT_W  = 14;
  localparam int ERR_W = 15;

  localparam logic [1:0] ACT_DRAW = 2'd0;
  localparam logic [1:0] ACT_READ = 2'd1;
  localparam logic [1:0] ACT_FILL = 2'd2;

  localparam logic [1:0] PEN_CLEAR  = 2'd0;
  localparam logic [1:0] PEN_SET    = 2'd1;
  localparam logic [1:0] PEN_INVERT = 2'd2;

  typedef enum logic [1:0] {
    CMD_DRAW,
    CMD_READ,
    CMD_FILL,
    CMD_NONE
  } cmd_e;

  typedef struct packed {
    cmd_e                     kind;
    logic signed [PT_W-1:0]   x0;
    logic signed [PT_W-1:0]   y0;
    logic signed [1:0]        sx;
    logic signed [1:0]        sy;
    logic [CRD_W-1:0]         dx;
    logic [CRD_W-1:0]         dy;
    logic [CRD_W-1:0]         major;
    logic [1:0]               pen;
    logic                     read_ok;
    logic [ADDR_W-1:0]        addr;
    logic [7:0]               fill_byte;
  } cmd_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

  function automatic logic [ADDR_W-1:0] fblp_addr(input logic [PAGE_W-1:0] page,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(page) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

[design/framebuffer_line_plotter.sv]
// Top level of the frame buffer line plotter.
// Connects the front end (fblp_front) and back end (fblp_back); uses fblp_pkg.
//
// Input channel: in_valid_i / in_stall_o with action, endpoints, pen mode and
// read address as separate ports. Output channel: out_valid_o / out_stall_i
// with read_data_o. Every input beat yields exactly one output beat, in order.
// A beat moves when valid is high and stall is low at a rising clk_i edge.
// Work per item in the back end:
//   draw: max(|dx|,|dy|)+1 points; each on-screen point reads and then
//         rewrites its store byte (PLOT, WRITE), off-screen points skip it;
//   read: READ, CAPTURE, RESULT (RESULT only when out of range);
//   unused action: RESULT only; fill: writes all STORE_SIZE (1056) bytes.
// The front end queues up to two beats, so input is taken while the back end
// works and while a result waits in the output register.
// Reset (rst_ni low, asynchronous) starts a clearing pass over the
// frame store; in_stall_o stays high until it ends.
// When the receiver stalls, the result holds in the output register, the back
// end waits with the next result, and the queue fills and then stalls input.
module framebuffer_line_plotter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic signed [11:0] x_start_i,
  input  logic signed [11:0] y_start_i,
  input  logic signed [11:0] x_end_i,
  input  logic signed [11:0] y_end_i,
  input  logic [1:0]         pen_mode_i,
  input  logic [2:0]         read_page_i,
  input  logic [7:0]         read_column_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         read_data_o
);
  import fblp_pkg::*;

  back_stat_t back_stat;
  logic       cmd_valid;
  cmd_t       cmd;

  fblp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .x_start_i     (x_start_i),
    .y_start_i     (y_start_i),
    .x_end_i       (x_end_i),
    .y_end_i       (y_end_i),
    .pen_mode_i    (pen_mode_i),
    .read_page_i   (read_page_i),
    .read_column_i (read_column_i),
    .back_stat_i   (back_stat),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd)
  );

  fblp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .back_stat_o (back_stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_data_o (read_data_o)
  );

endmodule

[design/fblp_front.sv]
// Front end of the line plotter: accepts input beats, classifies them into
// commands and holds them in a two-entry queue. Depends on fblp_pkg.
module fblp_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 action_i,
  input  logic signed [11:0]         x_start_i,
  input  logic signed [11:0]         y_start_i,
  input  logic signed [11:0]         x_end_i,
  input  logic signed [11:0]         y_end_i,
  input  logic [1:0]                 pen_mode_i,
  input  logic [2:0]                 read_page_i,
  input  logic [7:0]                 read_column_i,
  input  fblp_pkg::back_stat_t       back_stat_i,
  output logic                       cmd_valid_o,
  output fblp_pkg::cmd_t             cmd_o
);
  import fblp_pkg::*;

  logic signed [CRD_W:0]  dx_raw, dy_raw;
  logic [CRD_W-1:0]       dx_abs, dy_abs;
  logic [4:0]             page_wide;
  logic [8:0]             col_wide;
  cmd_t                   cmd_new;
  cmd_t                   entry_q [2];
  logic                   wr_ptr_q, rd_ptr_q;
  logic [1:0]             count_q;
  logic                   push, full;

  always_comb begin
    dx_raw = {x_end_i[11], x_end_i} - {x_start_i[11], x_start_i};
    dy_raw = {y_end_i[11], y_end_i} - {y_start_i[11], y_start_i};
    dx_abs = dx_raw[CRD_W] ? CRD_W'(-dx_raw) : CRD_W'(dx_raw);
    dy_abs = dy_raw[CRD_W] ? CRD_W'(-dy_raw) : CRD_W'(dy_raw);
    page_wide = 5'(read_page_i);
    col_wide  = 9'(read_column_i);

    unique case (action_i)
      ACT_DRAW: cmd_new.kind = CMD_DRAW;
      ACT_READ: cmd_new.kind = CMD_READ;
      ACT_FILL: cmd_new.kind = CMD_FILL;
      default:  cmd_new.kind = CMD_NONE;
    endcase
    cmd_new.x0 = {{(PT_W-12){x_start_i[11]}}, x_start_i};
    cmd_new.y0 = {{(PT_W-12){y_start_i[11]}}, y_start_i};
    cmd_new.sx = dx_raw[CRD_W] ? 2'sb11 : ((dx_raw == '0) ? 2'sb00 : 2'sb01);
    cmd_new.sy = dy_raw[CRD_W] ? 2'sb11 : ((dy_raw == '0) ? 2'sb00 : 2'sb01);
    cmd_new.dx = dx_abs;
    cmd_new.dy = dy_abs;
    cmd_new.major = (dx_abs > dy_abs) ? dx_abs : dy_abs;
    cmd_new.pen = pen_mode_i;
    cmd_new.read_ok = (page_wide < 5'(PAGES)) && (col_wide < 9'(COLUMNS));
    cmd_new.addr = fblp_addr(PAGE_W'(page_wide), COL_W'(col_wide));
    cmd_new.fill_byte = (pen_mode_i == PEN_SET) ? 8'hff : 8'h00;
  end

  assign full        = (count_q == 2'd2);
  assign in_stall_o  = full || back_stat_i.clearing;
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (back_stat_i.pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(push) - 2'(back_stat_i.pop);
    end
  end

endmodule

[design/fblp_back.sv]
// Back end of the line plotter: frame store memory, line stepper, sweep for
// fill and reset clear, and the output register. Depends on fblp_pkg.
module fblp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  fblp_pkg::cmd_t       cmd_i,
  output fblp_pkg::back_stat_t back_stat_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           read_data_o
);
  import fblp_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PLOT,
    ST_WRITE,
    ST_FILL,
    ST_READ,
    ST_CAPTURE,
    ST_RESULT
  } state_e;

  localparam logic signed [PT_W-1:0] COL_LIM   = PT_W'(COLUMNS);
  localparam logic signed [PT_W-1:0] ROW_LIM   = PT_W'(ROWS);
  localparam logic [ADDR_W-1:0]      LAST_ADDR = ADDR_W'(STORE_SIZE - 1);

  logic [7:0]              mem [STORE_SIZE];
  logic [7:0]              rdata_q;
  logic                    mem_we, mem_re;
  logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
  logic [7:0]              mem_wdata;

  state_e                  state_q;
  cmd_t                    cmd_q;
  logic signed [PT_W-1:0]  px_q, py_q;
  logic signed [ERR_W-1:0] ex_q, ey_q;
  logic [CRD_W-1:0]        cnt_q;
  logic [ADDR_W-1:0]       addr_q;
  logic [7:0]              res_q;
  logic                    out_valid_q;
  logic [7:0]              read_data_q;

  logic                    visible, last_pt;
  logic [ADDR_W-1:0]       plot_addr;
  logic [7:0]              pix_bit, new_byte;
  logic signed [ERR_W-1:0] ex_sum, ey_sum, ex_n, ey_n;
  logic signed [PT_W-1:0]  px_n, py_n;

  always_comb begin
    visible = !px_q[PT_W-1] && (px_q < COL_LIM) && !py_q[PT_W-1] && (py_q < ROW_LIM);
    plot_addr = fblp_addr(py_q[PAGE_W+2:3], px_q[COL_W-1:0]);
    pix_bit = 8'h01 << py_q[2:0];
    unique case (cmd_q.pen)
      PEN_CLEAR:  new_byte = rdata_q & ~pix_bit;
      PEN_SET:    new_byte = rdata_q | pix_bit;
      PEN_INVERT: new_byte = rdata_q ^ pix_bit;
      default:    new_byte = rdata_q;
    endcase

    ex_sum = ex_q + $signed({{(ERR_W-CRD_W){1'b0}}, cmd_q.dx});
    ey_sum = ey_q + $signed({{(ERR_W-CRD_W){1'b0}}, cmd_q.dy});
    if (ex_sum > $signed({{(ERR_W-CRD_W+1){1'b0}}, cmd_q.major[CRD_W-1:1]})) begin
      ex_n = ex_sum - $signed({{(ERR_W-CRD_W){1'b0}}, cmd_q.major});
      px_n = px_q + {{(PT_W-2){cmd_q.sx[1]}}, cmd_q.sx};
    end else begin
      ex_n = ex_sum;
      px_n = px_q;
    end
    if (ey_sum > $signed({{(ERR_W-CRD_W){1'b0}}, cmd_q.major})) begin
      ey_n = ey_sum - $signed({{(ERR_W-CRD_W){1'b0}}, cmd_q.major});
      py_n = py_q + {{(PT_W-2){cmd_q.sy[1]}}, cmd_q.sy};
    end else begin
      ey_n = ey_sum;
      py_n = py_q;
    end
    last_pt = (cnt_q == cmd_q.major);

    mem_we    = (state_q == ST_CLEAR) || (state_q == ST_FILL) || (state_q == ST_WRITE);
    mem_waddr = (state_q == ST_WRITE) ? plot_addr : addr_q;
    unique case (state_q)
      ST_WRITE: mem_wdata = new_byte;
      ST_FILL:  mem_wdata = cmd_q.fill_byte;
      default:  mem_wdata = 8'h00;
    endcase
    mem_re    = ((state_q == ST_PLOT) && visible) || (state_q == ST_READ);
    mem_raddr = (state_q == ST_READ) ? cmd_q.addr : plot_addr;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign back_stat_o.pop      = (state_q == ST_IDLE) && cmd_valid_i;
  assign back_stat_o.clearing = (state_q == ST_CLEAR);
  assign out_valid_o          = out_valid_q;
  assign read_data_o          = read_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cmd_q       <= '0;
      px_q        <= '0;
      py_q        <= '0;
      ex_q        <= '0;
      ey_q        <= '0;
      cnt_q       <= '0;
      addr_q      <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      read_data_q <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_RESULT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          addr_q <= addr_q + 1'b1;
          if (addr_q == LAST_ADDR) begin
            addr_q  <= '0;
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q  <= cmd_i;
            px_q   <= cmd_i.x0;
            py_q   <= cmd_i.y0;
            ex_q   <= ERR_W'(1);
            ey_q   <= ERR_W'(1);
            cnt_q  <= '0;
            addr_q <= '0;
            res_q  <= 8'h00;
            unique case (cmd_i.kind)
              CMD_DRAW: state_q <= ST_PLOT;
              CMD_READ: state_q <= cmd_i.read_ok ? ST_READ : ST_RESULT;
              CMD_FILL: state_q <= ST_FILL;
              default:  state_q <= ST_RESULT;
            endcase
          end
        end
        ST_PLOT: begin
          if (visible) begin
            state_q <= ST_WRITE;
          end else begin
            px_q  <= px_n;
            py_q  <= py_n;
            ex_q  <= ex_n;
            ey_q  <= ey_n;
            cnt_q <= cnt_q + 1'b1;
            if (last_pt) begin
              state_q <= ST_RESULT;
            end
          end
        end
        ST_WRITE: begin
          px_q  <= px_n;
          py_q  <= py_n;
          ex_q  <= ex_n;
          ey_q  <= ey_n;
          cnt_q <= cnt_q + 1'b1;
          state_q <= last_pt ? ST_RESULT : ST_PLOT;
        end
        ST_FILL: begin
          addr_q <= addr_q + 1'b1;
          if (addr_q == LAST_ADDR) begin
            state_q <= ST_RESULT;
          end
        end
        ST_READ: begin
          state_q <= ST_CAPTURE;
        end
        ST_CAPTURE: begin
          res_q   <= rdata_q;
          state_q <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            read_data_q <= res_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[design/fblp_checker.sv]
// Port-level checker for the frame buffer line plotter, bound to the top level.
// Tracks outstanding beats; no package dependency.
module fblp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] read_data_o
);

  logic [2:0] pend_q;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_beat = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 3'd0;
    end else begin
      pend_q <= pend_q + 3'(in_beat) - 3'(out_beat);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o))
    else $error("output beat changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 3'd0)
    else $error("output beat without an accepted input beat");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd4)
    else $error("too many beats in flight");

  a_clear_stall: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> in_stall_o && !out_valid_o)
    else $error("input taken or output shown during reset clear");

endmodule

bind framebuffer_line_plotter fblp_checker u_fblp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .read_data_o (read_data_o)
);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Testbench for framebuffer_line_plotter: random and directed lines, reads and fills
// checked against a pixel-level model of the frame store. Depends on fblp_pkg.
module testbench;
  import fblp_pkg::*;

  localparam logic [1:0] ACT_NOP  = 2'd3;
  localparam logic [1:0] PEN_KEEP = 2'd3;
  localparam logic signed [11:0] X_LAST = 12'(COLUMNS - 1);
  localparam logic signed [11:0] Y_LAST = 12'(ROWS - 1);

  class pixel_scoreboard;
    logic [7:0] frame[STORE_SIZE];
    logic [7:0] pending_bytes[$];
    int lines_seen, reads_seen, fills_seen, unused_seen;
    int beats_checked, mismatches;

    function new();
      foreach (frame[i]) frame[i] = 8'h00;
    endfunction

    function void plot_point(int x, int y, logic [1:0] pen);
      int idx;
      logic [7:0] mask;
      if (x < 0 || x > COLUMNS - 1 || y < 0 || y > ROWS - 1) return;
      idx  = (y / 8) * COLUMNS + x;
      mask = 8'h01 << (y % 8);
      case (pen)
        PEN_CLEAR:  frame[idx] = frame[idx] & ~mask;
        PEN_SET:    frame[idx] = frame[idx] | mask;
        PEN_INVERT: frame[idx] = frame[idx] ^ mask;
        default:    ;
      endcase
    endfunction

    function void trace_line(int x0, int y0, int x1, int y1, logic [1:0] pen);
      int dx, dy, sx, sy, span, ex, ey, px, py, t;
      dx = x1 - x0;
      dy = y1 - y0;
      sx = (dx > 0) ? 1 : ((dx == 0) ? 0 : -1);
      sy = (dy > 0) ? 1 : ((dy == 0) ? 0 : -1);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      span = (dx > dy) ? dx : dy;
      ex = 1;
      ey = 1;
      px = x0;
      py = y0;
      for (t = 0; t <= span; t++) begin
        plot_point(px, py, pen);
        ex += dx;
        ey += dy;
        if (ex > span / 2) begin
          ex -= span;
          px += sx;
        end
        if (ey > span) begin
          ey -= span;
          py += sy;
        end
      end
    endfunction

    function void note_beat(logic [1:0] act, logic signed [11:0] xs, logic signed [11:0] ys,
                            logic signed [11:0] xe, logic signed [11:0] ye, logic [1:0] pen,
                            logic [2:0] page, logic [7:0] col);
      logic [7:0] data;
      data = 8'h00;
      case (act)
        ACT_DRAW: begin
          trace_line(int'(xs), int'(ys), int'(xe), int'(ye), pen);
          lines_seen++;
        end
        ACT_READ: begin
          if (int'(page) < PAGES && int'(col) < COLUMNS)
            data = frame[int'(page) * COLUMNS + int'(col)];
          reads_seen++;
        end
        ACT_FILL: begin
          foreach (frame[i]) frame[i] = (pen == PEN_SET) ? 8'hFF : 8'h00;
          fills_seen++;
        end
        default: unused_seen++;
      endcase
      pending_bytes.push_back(data);
    endfunction

    function void check_beat(logic [7:0] got);
      logic [7:0] want;
      if (pending_bytes.size() == 0) begin
        $error("read_data 0x%02h arrived with no beat outstanding", got);
        mismatches++;
        return;
      end
      want = pending_bytes.pop_front();
      beats_checked++;
      if (got !== want) begin
        $error("read_data mismatch: expected 0x%02h, actual 0x%02h", want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         action_i;
  logic signed [11:0] x_start_i;
  logic signed [11:0] y_start_i;
  logic signed [11:0] x_end_i;
  logic signed [11:0] y_end_i;
  logic [1:0]         pen_mode_i;
  logic [2:0]         read_page_i;
  logic [7:0]         read_column_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [7:0]         read_data_o;

  pixel_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;
  int cycle_budget = 20000;

  framebuffer_line_plotter i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .x_start_i    (x_start_i),
    .y_start_i    (y_start_i),
    .x_end_i      (x_end_i),
    .y_end_i      (y_end_i),
    .pen_mode_i   (pen_mode_i),
    .read_page_i  (read_page_i),
    .read_column_i(read_column_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 4 * cycle_budget) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.note_beat(action_i, x_start_i, y_start_i, x_end_i, y_end_i, pen_mode_i,
                   read_page_i, read_column_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_beat(read_data_o);
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Enter and leave at a falling edge; hold the beat until it is taken.
  task automatic send_beat(input logic [1:0] act, input logic signed [11:0] xs,
                           input logic signed [11:0] ys, input logic signed [11:0] xe,
                           input logic signed [11:0] ye, input logic [1:0] pen,
                           input logic [2:0] page, input logic [7:0] col);
    int ddx, ddy;
    ddx = int'(xe) - int'(xs);
    ddy = int'(ye) - int'(ys);
    if (ddx < 0) ddx = -ddx;
    if (ddy < 0) ddy = -ddy;
    case (act)
      ACT_DRAW: cycle_budget += 2 * (((ddx > ddy) ? ddx : ddy) + 1) + 80;
      ACT_FILL: cycle_budget += STORE_SIZE + 80;
      default:  cycle_budget += 80;
    endcase
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    x_start_i     <= xs;
    y_start_i     <= ys;
    x_end_i       <= xe;
    y_end_i       <= ye;
    pen_mode_i    <= pen;
    read_page_i   <= page;
    read_column_i <= col;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  function automatic logic signed [11:0] pick_coord(int lo, int hi);
    return 12'($urandom_range(hi - lo) + lo);
  endfunction

  function automatic logic [1:0] pick_pen();
    int r;
    r = $urandom_range(99);
    if (r < 40) return PEN_SET;
    if (r < 65) return PEN_INVERT;
    if (r < 90) return PEN_CLEAR;
    return PEN_KEEP;
  endfunction

  task automatic send_random_beat();
    int r;
    logic signed [11:0] xs, ys, xe, ye;
    logic [2:0] page;
    logic [7:0] col;
    r    = $urandom_range(99);
    xs   = 12'($urandom_range(4095));
    ys   = 12'($urandom_range(4095));
    xe   = 12'($urandom_range(4095));
    ye   = 12'($urandom_range(4095));
    page = 3'($urandom_range(7));
    col  = 8'($urandom_range(255));
    if (r < 55) begin
      xs = pick_coord(-20, COLUMNS + 19);
      ys = pick_coord(-20, ROWS + 19);
      if ($urandom_range(1)) begin
        xe = 12'(int'(xs) + $urandom_range(16) - 8);
        ye = 12'(int'(ys) + $urandom_range(16) - 8);
      end else begin
        xe = pick_coord(-20, COLUMNS + 19);
        ye = pick_coord(-20, ROWS + 19);
      end
      send_beat(ACT_DRAW, xs, ys, xe, ye, pick_pen(), page, col);
    end else if (r < 62) begin
      send_beat(ACT_DRAW, pick_coord(-400, 400), pick_coord(-400, 400),
                pick_coord(-400, 400), pick_coord(-400, 400), pick_pen(), page, col);
    end else if (r < 64) begin
      send_beat(ACT_DRAW, xs, ys, xe, ye, pick_pen(), page, col);
    end else if (r < 92) begin
      if ($urandom_range(9) != 0) col = 8'($urandom_range(COLUMNS - 1));
      send_beat(ACT_READ, xs, ys, xe, ye, 2'($urandom_range(3)), page, col);
    end else if (r < 96) begin
      send_beat(ACT_FILL, xs, ys, xe, ye, 2'($urandom_range(3)), page, col);
    end else begin
      send_beat(ACT_NOP, xs, ys, xe, ye, 2'($urandom_range(3)), page, col);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    action_i      = ACT_DRAW;
    x_start_i     = '0;
    y_start_i     = '0;
    x_end_i       = '0;
    y_end_i       = '0;
    pen_mode_i    = PEN_CLEAR;
    read_page_i   = '0;
    read_column_i = '0;
    out_stall_i   = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_beat(ACT_READ, 0, 0, 0, 0, PEN_CLEAR, 3'd0, 8'd0);
    send_beat(ACT_DRAW, 0, 0, 0, 0, PEN_SET, 3'd0, 8'd0);
    send_beat(ACT_DRAW, X_LAST, Y_LAST, X_LAST, Y_LAST, PEN_SET, 3'd0, 8'd0);
    send_beat(ACT_READ, 0, 0, 0, 0, PEN_CLEAR, 3'd0, 8'd0);
    send_beat(ACT_READ, 0, 0, 0, 0, PEN_CLEAR, 3'd7, 8'(COLUMNS - 1));
    send_beat(ACT_DRAW, 0, 5, X_LAST, 5, PEN_SET, 3'd0, 8'd0);
    send_beat(ACT_DRAW, 10, Y_LAST, 10, 0, PEN_INVERT, 3'd0, 8'd0);
    send_beat(ACT_DRAW, 20, 0, 27, Y_LAST, PEN_SET, 3'd0, 8'd0);
    send_beat(ACT_DRAW, X_LAST, 0, 0, Y_LAST, PEN_CLEAR, 3'd0, 8'd0);
    send_beat(ACT_DRAW, 0, 0, X_LAST, Y_LAST, PEN_KEEP, 3'd0, 8'd0);
    send_beat(ACT_DRAW, -2048, -2048, 2047, 2047, PEN_SET, 3'd0, 8'd0);
    send_beat(ACT_DRAW, 2047, -2048, -2048, 2047, PEN_INVERT, 3'd0, 8'd0);
    send_beat(ACT_READ, 0, 0, 0, 0, PEN_CLEAR, 3'd0, 8'd10);
    send_beat(ACT_READ, 0, 0, 0, 0, PEN_CLEAR, 3'd3, 8'd20);
    send_beat(ACT_READ, 0, 0, 0, 0, PEN_CLEAR, 3'd0, 8'(COLUMNS));
    send_beat(ACT_READ, -1, -1, -1, -1, PEN_KEEP, 3'd7, 8'd255);
    send_beat(ACT_NOP, 2047, -2048, -1, 0, PEN_SET, 3'd7, 8'd255);
    send_beat(ACT_FILL, 0, 0, 0, 0, PEN_SET, 3'd0, 8'd0);
    send_beat(ACT_READ, 0, 0, 0, 0, PEN_CLEAR, 3'd4, 8'd77);
    send_beat(ACT_DRAW, 5, 5, 40, 17, PEN_CLEAR, 3'd0, 8'd0);
    send_beat(ACT_READ, 0, 0, 0, 0, PEN_CLEAR, 3'd0, 8'd5);
    send_beat(ACT_FILL, 0, 0, 0, 0, PEN_INVERT, 3'd0, 8'd0);
    send_beat(ACT_READ, 0, 0, 0, 0, PEN_CLEAR, 3'd7, 8'(COLUMNS - 1));
    send_beat(ACT_FILL, 0, 0, 0, 0, PEN_KEEP, 3'd0, 8'd0);

    repeat (200) send_random_beat();
    send_idle_pct = 88;
    repeat (200) send_random_beat();
    send_idle_pct  = 0;
    recv_stall_pct = 88;
    repeat (200) send_random_beat();
    send_idle_pct  = 14;
    recv_stall_pct = 14;
    repeat (200) send_random_beat();
    in_valid_i <= 1'b0;
    recv_stall_pct = 0;

    while (sb.pending_bytes.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("covered %0d lines, %0d reads, %0d fills, %0d unused actions over four idle phases",
             sb.lines_seen, sb.reads_seen, sb.fills_seen, sb.unused_seen);
    $display("%0d result beats checked, %0d mismatches", sb.beats_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_bytes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
